>>> rtl/core/mck_pkg.sv
package mck_pkg;

   localparam int CharW = 8;
   localparam int PatW  = 23;
   localparam int IdxW  = 6;

   typedef logic [CharW-1:0] char_type;
   typedef logic [PatW-1:0]  pattern_type;
   typedef logic [IdxW-1:0]  index_type;

   localparam char_type CharSpace = 8'h20;
   localparam char_type CharLong  = 8'h21;
   localparam char_type CharDummy = 8'h40;
   localparam char_type CharDig0  = 8'h30;
   localparam char_type CharDig9  = 8'h39;
   localparam char_type CharLowA  = 8'h61;
   localparam char_type CharLowZ  = 8'h7A;
   localparam char_type CharUpA   = 8'h41;
   localparam char_type CharUpZ   = 8'h5A;
   localparam char_type DigOffset = 8'd22;

   localparam index_type IdxSpace = 6'd36;
   localparam index_type IdxLong  = 6'd37;

   typedef struct packed {
      logic load;   // take a new request and look up its pattern
      logic shift;  // move one key unit into the output register
   } dp_cmd_type;

   typedef struct packed {
      logic out_valid;  // output register holds a unit not yet taken
      logic unit_last;  // the unit at the head of the pattern is the final one
   } dp_status_type;

   function automatic index_type char_index(input char_type c);
      index_type idx;
      char_type  diff;
      idx  = IdxSpace;
      diff = '0;
      if (c == CharSpace) begin
         idx = IdxSpace;
      end else if (c == CharLong) begin
         idx = IdxLong;
      end else if (c >= CharDig0 && c <= CharDig9) begin
         diff = c - DigOffset;
         idx  = diff[IdxW-1:0];
      end else if (c >= CharLowA && c <= CharLowZ) begin
         diff = c - CharLowA;
         idx  = diff[IdxW-1:0];
      end else if (c >= CharUpA && c <= CharUpZ) begin
         diff = c - CharUpA;
         idx  = diff[IdxW-1:0];
      end
      return idx;
   endfunction

   // Key pattern, LSB first; the highest set bit is the stop flag.
   function automatic pattern_type pattern_lookup(input index_type idx);
      pattern_type p;
      case (idx)
         6'd0:    p = 23'h00011D;
         6'd1:    p = 23'h001157;
         6'd2:    p = 23'h0045D7;
         6'd3:    p = 23'h000457;
         6'd4:    p = 23'h000011;
         6'd5:    p = 23'h001175;
         6'd6:    p = 23'h001177;
         6'd7:    p = 23'h000455;
         6'd8:    p = 23'h000045;
         6'd9:    p = 23'h011DDD;
         6'd10:   p = 23'h0011D7;
         6'd11:   p = 23'h00115D;
         6'd12:   p = 23'h000477;
         6'd13:   p = 23'h000117;
         6'd14:   p = 23'h004777;
         6'd15:   p = 23'h0022DD;
         6'd16:   p = 23'h011D77;
         6'd17:   p = 23'h00045D;
         6'd18:   p = 23'h000115;
         6'd19:   p = 23'h000047;
         6'd20:   p = 23'h000475;
         6'd21:   p = 23'h0011D5;
         6'd22:   p = 23'h0011DD;
         6'd23:   p = 23'h004757;
         6'd24:   p = 23'h011DD7;
         6'd25:   p = 23'h004577;
         6'd26:   p = 23'h477777;
         6'd27:   p = 23'h11DDDD;
         6'd28:   p = 23'h047775;
         6'd29:   p = 23'h011DD5;
         6'd30:   p = 23'h004755;
         6'd31:   p = 23'h001155;
         6'd32:   p = 23'h004557;
         6'd33:   p = 23'h011577;
         6'd34:   p = 23'h045777;
         6'd35:   p = 23'h117777;
         6'd36:   p = 23'h000010;
         6'd37:   p = 23'h000080;
         default: p = 23'h000010;
      endcase
      return p;
   endfunction

endpackage

>>> rtl/core/mck_ctrl.sv
module mck_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   rsp_tready,
   input  mck_pkg::dp_status_type status,
   output mck_pkg::dp_cmd_type    cmd
);
   import mck_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_SHIFT = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      can_shift;

   assign can_shift = !status.out_valid || rsp_tready;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
            if (req_tvalid) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            cmd.shift = can_shift;
            if (can_shift && status.unit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/core/mck_dp.sv
module mck_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  mck_pkg::char_type      req_char,
   input  logic                   req_phrase_start,
   input  logic                   rsp_tready,
   input  mck_pkg::dp_cmd_type    cmd,
   output mck_pkg::dp_status_type status,
   output logic                   rsp_tvalid,
   output logic                   rsp_key_on,
   output logic                   rsp_last_unit
);
   import mck_pkg::*;

   char_type    prev_ff, prev_in;
   pattern_type pat_ff, pat_in;
   logic        out_valid_ff, out_valid_in;
   logic        key_ff, key_in;
   logic        last_ff, last_in;
   char_type    prev_eff;
   char_type    char_eff;
   logic        head_last;

   // a space right after a space or long space is sent as a long space
   always_comb begin
      prev_eff = req_phrase_start ? CharDummy : prev_ff;
      char_eff = req_char;
      if (req_char == CharSpace && (prev_eff == CharSpace || prev_eff == CharLong)) begin
         char_eff = CharLong;
      end
   end

   assign head_last = (pat_ff[PatW-1:1] == {{(PatW-2){1'b0}}, 1'b1});

   always_comb begin
      prev_in      = prev_ff;
      pat_in       = pat_ff;
      out_valid_in = out_valid_ff;
      key_in       = key_ff;
      last_in      = last_ff;
      if (cmd.load) begin
         prev_in = char_eff;
         pat_in  = pattern_lookup(char_index(char_eff));
      end
      if (cmd.shift) begin
         pat_in       = {1'b0, pat_ff[PatW-1:1]};
         out_valid_in = 1'b1;
         key_in       = pat_ff[0];
         last_in      = head_last;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= CharDummy;
         out_valid_ff <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pat_ff  <= pat_in;
      key_ff  <= key_in;
      last_ff <= last_in;
   end

   assign status.out_valid = out_valid_ff;
   assign status.unit_last = head_last;
   assign rsp_tvalid       = out_valid_ff;
   assign rsp_key_on       = key_ff;
   assign rsp_last_unit    = last_ff;

`ifndef SYNTHESIS
   a_shift_has_units: assert property (@(posedge clock) disable iff (reset)
      cmd.shift |-> (pat_ff[PatW-1:1] != '0))
      else $error("shift with empty pattern");

   a_load_excl_shift: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.shift))
      else $error("load and shift in the same cycle");

   a_last_empties_pattern: assert property (@(posedge clock) disable iff (reset)
      (cmd.shift && head_last) |=> (pat_ff == {{(PatW-1){1'b0}}, 1'b1}))
      else $error("pattern not at stop flag after last unit");
`endif

endmodule

>>> rtl/core/morse_code_keyer_unit.sv
// Morse keyer: one ASCII character per request, one key unit per result.
// A request's pattern is loaded on acceptance; its 4 to 22 units then
// shift into the output register one per cycle, stalled by rsp_tready;
// the next request is taken only after the last unit of the previous.
// Reset (synchronous, active high) empties the output and sets the
// previous character to the dummy code.
module morse_code_keyer_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   input  logic       req_tuser,   // [0] phrase_start
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [0] key_on, [7:1] zero
   output logic       rsp_tlast    // last_unit
);
   import mck_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          key_on;

   mck_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mck_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_char         (req_tdata),
      .req_phrase_start (req_tuser),
      .rsp_tready       (rsp_tready),
      .cmd              (cmd),
      .status           (status),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_key_on       (key_on),
      .rsp_last_unit    (rsp_tlast)
   );

   assign rsp_tdata = {7'b0, key_on};

endmodule

>>> tb/tb_morse_code_keyer_unit.sv
`timescale 1ns / 1ps

module tb_morse_code_keyer_unit;
   import mck_pkg::*;

   localparam int DigitBase = 26;
   localparam int LongHoldCycles = 200;
   localparam int DrainCycles = 30;

   typedef struct packed {
      char_type code;
      logic     phrase_start;
      int       gap;
      bit       drain;     // hold this request until every unit so far is out
   } char_req_type;

   typedef struct packed {
      logic key_on;
      logic last_unit;
   } key_unit_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] char_code
   logic       req_tuser = 1'b0;    // [0] phrase_start
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [0] key_on, [7:1] zero
   logic       rsp_tlast;           // last_unit

   morse_code_keyer_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   pattern_type  key_table [38];
   char_type     prev_char;
   char_req_type pending_chars [$];
   key_unit_type units_due [$];

   char_req_type cur_char;
   bit        staged = 1'b0;
   int        send_wait = 0;
   int        recv_wait = 0;
   int        long_hold_left = 0;
   bit        long_hold_done = 1'b0;
   logic      req_taken = 1'b0;
   logic      rsp_taken = 1'b0;

   int errors = 0;
   int chars_sent = 0;
   int phrase_starts = 0;
   int long_spaces = 0;
   int unknown_chars = 0;
   int units_seen = 0;

   initial forever #1 clock = ~clock;

   initial begin
      #5_000_000;
      $display("Timeout: %0d units still due", units_due.size());
      $display("Regression FAIL");
      $finish;
   end

   // mode 0: never idle, 1: idle 0..14 every time, 2: mostly back to back
   function automatic int draw_wait(input int mode);
      int w;
      w = 0;
      if (mode == 1) begin
         w = int'($urandom_range(0, 14));
      end else if (mode == 2 && $urandom_range(0, 3) == 0) begin
         w = int'($urandom_range(0, 14));
      end
      return w;
   endfunction

   function automatic void predict_units(input char_type code_in, input logic ps);
      char_type     c;
      pattern_type  pat;
      int           idx;
      key_unit_type u;
      c = code_in;
      if (ps) begin
         prev_char = CharDummy;
      end
      // a space right after a space or long space widens to a long space
      if (c == CharSpace && (prev_char == CharSpace || prev_char == CharLong)) begin
         c = CharLong;
      end
      idx = int'(IdxSpace);
      if (c == CharLong) begin
         idx = int'(IdxLong);
         long_spaces++;
      end else if (c >= CharDig0 && c <= CharDig9) begin
         idx = DigitBase + int'(c) - int'(CharDig0);
      end else if (c >= CharLowA && c <= CharLowZ) begin
         idx = int'(c) - int'(CharLowA);
      end else if (c >= CharUpA && c <= CharUpZ) begin
         idx = int'(c) - int'(CharUpA);
      end else if (c != CharSpace) begin
         unknown_chars++;
      end
      pat = key_table[idx];
      while (pat > pattern_type'(1)) begin
         u.key_on    = pat[0];
         pat         = pat >> 1;
         u.last_unit = (pat == pattern_type'(1));
         units_due.push_back(u);
      end
      prev_char = c;
   endfunction

   // request side
   always @(negedge clock) begin : sender
      logic vld;
      vld = req_tvalid;
      if (reset) begin
         vld = 1'b0;
      end else begin
         if (req_taken) begin
            vld = 1'b0;
         end
         if (!vld && !staged && pending_chars.size() != 0) begin
            cur_char  = pending_chars.pop_front();
            staged    = 1'b1;
            send_wait = cur_char.gap;
         end
         if (!vld && staged && !(cur_char.drain && units_due.size() != 0)) begin
            if (send_wait == 0) begin
               vld    = 1'b1;
               staged = 1'b0;
               req_tdata <= cur_char.code;
               req_tuser <= cur_char.phrase_start;
            end else begin
               send_wait--;
            end
         end
      end
      req_tvalid <= vld;
   end

   // response side; one long hold-off once a few hundred units have passed
   always @(negedge clock) begin : receiver
      logic rdy;
      rdy = rsp_tready;
      if (reset) begin
         rdy = 1'b0;
      end else begin
         if (rsp_taken) begin
            rdy       = 1'b0;
            recv_wait = draw_wait((units_seen / 400) % 3);
         end
         if (!long_hold_done && units_seen >= 300) begin
            long_hold_done = 1'b1;
            long_hold_left = LongHoldCycles;
         end
         if (long_hold_left > 0) begin
            long_hold_left--;
            rdy = 1'b0;
         end else if (!rdy) begin
            if (recv_wait == 0) begin
               rdy = 1'b1;
            end else begin
               recv_wait--;
            end
         end
      end
      rsp_tready <= rdy;
   end

   always @(posedge clock) begin : monitor
      key_unit_type u;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         rsp_taken <= rsp_tvalid && rsp_tready;
         if (req_tvalid && req_tready) begin
            chars_sent++;
            if (req_tuser) begin
               phrase_starts++;
            end
            predict_units(req_tdata, req_tuser);
         end
         if (rsp_tvalid && rsp_tready) begin
            units_seen++;
            if (units_due.size() == 0) begin
               $error("unexpected key unit: key_on=%0b last_unit=%0b", rsp_tdata[0], rsp_tlast);
               errors++;
            end else begin
               u = units_due.pop_front();
               if (rsp_tdata[0] !== u.key_on) begin
                  $error("key_on mismatch: expected %0b actual %0b", u.key_on, rsp_tdata[0]);
                  errors++;
               end
               if (rsp_tlast !== u.last_unit) begin
                  $error("last_unit mismatch: expected %0b actual %0b", u.last_unit, rsp_tlast);
                  errors++;
               end
               if (rsp_tdata[7:1] !== 7'd0) begin
                  $error("pad mismatch: expected 0 actual %0h", rsp_tdata[7:1]);
                  errors++;
               end
            end
         end
      end
   end

   function automatic void queue_char(input char_type c, input logic ps, input int gap,
                                      input bit drain);
      char_req_type r;
      r.code         = c;
      r.phrase_start = ps;
      r.gap          = gap;
      r.drain        = drain;
      pending_chars.push_back(r);
   endfunction

   initial begin : stimulus
      char_type code;
      int       sel;
      int       gap;
      key_table = '{
         23'h00011D, 23'h001157, 23'h0045D7, 23'h000457, 23'h000011, 23'h001175,
         23'h001177, 23'h000455, 23'h000045, 23'h011DDD, 23'h0011D7, 23'h00115D,
         23'h000477, 23'h000117, 23'h004777, 23'h0022DD, 23'h011D77, 23'h00045D,
         23'h000115, 23'h000047, 23'h000475, 23'h0011D5, 23'h0011DD, 23'h004757,
         23'h011DD7, 23'h004577, 23'h477777, 23'h11DDDD, 23'h047775, 23'h011DD5,
         23'h004755, 23'h001155, 23'h004557, 23'h011577, 23'h045777, 23'h117777,
         23'h000010, 23'h000080
      };
      prev_char = CharDummy;

      // directed: space runs, phrase restart, range edges, unknown codes
      queue_char(CharSpace, 1'b0, 0, 1'b0);
      queue_char(CharSpace, 1'b0, 3, 1'b0);
      queue_char(CharSpace, 1'b0, 0, 1'b0);
      queue_char(CharLong, 1'b0, 7, 1'b0);
      queue_char(CharSpace, 1'b0, 0, 1'b0);
      queue_char(CharSpace, 1'b1, 2, 1'b0);
      queue_char(CharUpA, 1'b0, 0, 1'b0);
      queue_char(CharUpZ, 1'b0, 14, 1'b0);
      queue_char(CharLowA, 1'b0, 0, 1'b0);
      queue_char(CharLowZ, 1'b0, 1, 1'b0);
      queue_char(CharDig0, 1'b0, 0, 1'b0);
      queue_char(CharDig9, 1'b0, 5, 1'b0);
      queue_char(8'h00, 1'b0, 0, 1'b0);
      queue_char(8'hFF, 1'b1, 0, 1'b0);
      queue_char(8'h80, 1'b0, 9, 1'b0);
      queue_char(CharSpace, 1'b0, 0, 1'b0);   // after unknown: stays a word space
      queue_char(8'h7F, 1'b0, 0, 1'b0);
      queue_char(CharDummy, 1'b0, 4, 1'b0);
      queue_char(8'h5B, 1'b0, 0, 1'b0);
      queue_char(8'h60, 1'b0, 0, 1'b0);
      queue_char(8'h7B, 1'b0, 12, 1'b0);
      queue_char(8'h2F, 1'b0, 0, 1'b0);
      queue_char(8'h3A, 1'b0, 0, 1'b0);
      queue_char(CharLong, 1'b1, 0, 1'b0);
      queue_char(CharSpace, 1'b0, 0, 1'b0);

      // random text: mostly letters, digits and space runs, some raw bytes
      for (int i = 0; i < 500; i++) begin
         sel = int'($urandom_range(0, 99));
         if (sel < 30) begin
            code = char_type'(int'(CharUpA) + int'($urandom_range(0, 25)));
         end else if (sel < 60) begin
            code = char_type'(int'(CharLowA) + int'($urandom_range(0, 25)));
         end else if (sel < 72) begin
            code = char_type'(int'(CharDig0) + int'($urandom_range(0, 9)));
         end else if (sel < 88) begin
            code = CharSpace;
         end else if (sel < 92) begin
            code = CharLong;
         end else begin
            code = char_type'($urandom_range(0, 255));
         end
         gap = draw_wait((i / 100) % 3);
         queue_char(code, $urandom_range(0, 19) == 0, gap,
                    i == 0 || $urandom_range(0, 39) == 0);
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_chars.size() != 0 || staged || req_tvalid) begin
         @(posedge clock);
      end
      while (units_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);

      if (units_due.size() != 0) begin
         $error("%0d key units never arrived", units_due.size());
         errors++;
      end
      $display("Keyed %0d characters (%0d phrase starts, %0d long spaces, %0d unknown codes)",
               chars_sent, phrase_starts, long_spaces, unknown_chars);
      $display("Checked %0d key units with random and long response stalls", units_seen);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
